@@ design/term_frequency_index_top3_core_assert.svh @@
// Assertion macros shared by the index core.
`ifndef TERM_FREQUENCY_INDEX_TOP3_CORE_ASSERT_SVH
`define TERM_FREQUENCY_INDEX_TOP3_CORE_ASSERT_SVH

// Condition a at a clock edge implies condition c at the same edge.
`define TFI_ASSERT_NOW(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error(msg);

// Condition a at a clock edge implies condition c at the next edge.
`define TFI_ASSERT_NEXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);

`endif

@@ design/tfi_pkg.sv @@
package tfi_pkg;

	localparam int WORD_CHARS = 20;
	localparam int WORD_BITS  = 8 * WORD_CHARS;

	localparam logic [4:0] MIN_LEN_RESET = 5'd3;

	localparam logic [2:0] ST_COUNTED   = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_FOUND     = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_LONG      = 3'd5;

	typedef enum logic [1:0] {
		ACT_INDEX,
		ACT_QUERY,
		ACT_SHORT,
		ACT_LONG
	} act_t;

	typedef struct packed {
		act_t                   act;
		logic [WORD_BITS-1:0]   word;
		logic [5:0]             doc;
	} item_t;

endpackage

@@ design/tfi_ram.sv @@
module tfi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/tfi_front.sv @@
module tfi_front #(
	parameter int MAX_DOCS     = 64,
	parameter int MAX_WORD_LEN = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          min_word_length_we,
	input  logic [4:0]    min_word_length,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          kind,
	input  logic [63:0]   word_head,
	input  logic [63:0]   word_middle,
	input  logic [31:0]   word_tail,
	input  logic [5:0]    word_length,
	input  logic [5:0]    doc_index,
	output logic          q_valid,
	input  logic          q_pop,
	output tfi_pkg::item_t q_item,
	output logic [1:0]    q_level
);
	import tfi_pkg::*;

	logic [4:0] min_len_q;
	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       push;
	logic [WORD_BITS-1:0] raw;

	assign raw = {word_tail, word_middle, word_head};

	// Bytes past the word length are cleared so that lookups compare whole words.
	always_comb begin
		for (int b = 0; b < WORD_CHARS; b++) begin
			cls.word[8*b +: 8] = raw[8*b +: 8] & {8{6'(b) < word_length}};
		end
		cls.doc = doc_index;
		if (int'(word_length) > MAX_WORD_LEN) begin
			cls.act = ACT_LONG;
		end else if (kind) begin
			cls.act = ACT_QUERY;
		end else if (word_length <= {1'b0, min_len_q} || int'(doc_index) >= MAX_DOCS) begin
			cls.act = ACT_SHORT;
		end else begin
			cls.act = ACT_INDEX;
		end
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rd_ptr_q];
	assign q_level  = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LEN_RESET;
			wr_ptr_q  <= 1'b0;
			rd_ptr_q  <= 1'b0;
			cnt_q     <= 2'd0;
		end else begin
			if (min_word_length_we) begin
				min_len_q <= min_word_length;
			end
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

endmodule

@@ design/tfi_back.sv @@
module tfi_back #(
	parameter int MAX_WORDS   = 1024,
	parameter int MAX_DOCS    = 64,
	parameter int COUNT_WIDTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_pop,
	input  tfi_pkg::item_t q_item,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [2:0]     status,
	output logic [5:0]     doc_first,
	output logic [5:0]     doc_second,
	output logic [5:0]     doc_third
);
	import tfi_pkg::*;

	localparam int WIW = $clog2(MAX_WORDS);
	localparam int TW  = $clog2(MAX_WORDS + 1);
	localparam int DW  = $clog2(MAX_DOCS);
	localparam int DCW = $clog2(MAX_DOCS + 1);
	localparam int CA  = WIW + DW;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_SRCH, S_INC_RD, S_INC_WR, S_RANK, S_RESP
	} state_t;

	state_t                 state_q;
	item_t                  item_q;
	logic [TW-1:0]          total_q;
	logic [TW-1:0]          srch_idx_q;
	logic                   cmp_v_q;
	logic [WIW-1:0]         cmp_idx_q;
	logic [WIW-1:0]         place_q;
	logic [CA-1:0]          clr_addr_q;
	logic [DCW-1:0]         rank_d_q;
	logic                   rank_v_q;
	logic [DW-1:0]          rank_tag_q;
	logic [DW-1:0]          best_doc_q [3];
	logic [COUNT_WIDTH-1:0] best_cnt_q [3];
	logic [1:0]             fill_q;
	logic [2:0]             res_status_q;
	logic [5:0]             res_doc_q [3];

	logic                   v_we;
	logic [WIW-1:0]         v_raddr;
	logic [WORD_BITS-1:0]   v_rdata;
	logic                   c_we;
	logic [CA-1:0]          c_waddr;
	logic [COUNT_WIDTH-1:0] c_wdata;
	logic [CA-1:0]          c_raddr;
	logic [COUNT_WIDTH-1:0] c_rdata;
	logic                   match;
	logic                   out_free;
	logic [DW-1:0]          nb_doc [3];
	logic [COUNT_WIDTH-1:0] nb_cnt [3];

	assign v_we    = (state_q == S_SRCH) && !match && (srch_idx_q == total_q) && !cmp_v_q
		&& (item_q.act == ACT_INDEX) && (int'(total_q) < MAX_WORDS);
	assign v_raddr = srch_idx_q[WIW-1:0];
	assign match   = cmp_v_q && (v_rdata == item_q.word);

	tfi_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_WORDS)) u_vocab (
		.clk   (clk),
		.we    (v_we),
		.waddr (total_q[WIW-1:0]),
		.wdata (item_q.word),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	assign c_we    = (state_q == S_CLEAR) || (state_q == S_INC_WR);
	assign c_waddr = (state_q == S_CLEAR) ? clr_addr_q : {place_q, DW'(item_q.doc)};
	assign c_wdata = (state_q == S_CLEAR) ? '0 :
		((c_rdata < CNT_MAX) ? c_rdata + 1'b1 : c_rdata);
	assign c_raddr = (state_q == S_RANK) ? {place_q, rank_d_q[DW-1:0]}
		: {place_q, DW'(item_q.doc)};

	tfi_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(2 ** CA)) u_counts (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	// One insertion step of the top-three list: a displaced entry moves down.
	always_comb begin
		logic [DW-1:0]          cd;
		logic [COUNT_WIDTH-1:0] cc;
		logic                   carry;
		cd    = rank_tag_q;
		cc    = c_rdata;
		carry = 1'b1;
		for (int j = 0; j < 3; j++) begin
			nb_doc[j] = best_doc_q[j];
			nb_cnt[j] = best_cnt_q[j];
			if (carry) begin
				if (fill_q <= 2'(j)) begin
					nb_doc[j] = cd;
					nb_cnt[j] = cc;
					carry     = 1'b0;
				end else if (cc > best_cnt_q[j] || (cc == best_cnt_q[j] && cd < best_doc_q[j])) begin
					nb_doc[j] = cd;
					nb_cnt[j] = cc;
					cd        = best_doc_q[j];
					cc        = best_cnt_q[j];
				end
			end
		end
	end

	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_addr_q <= '0;
			total_q    <= '0;
			srch_idx_q <= '0;
			cmp_v_q    <= 1'b0;
			rank_v_q   <= 1'b0;
			rank_d_q   <= '0;
			fill_q     <= 2'd0;
			out_valid  <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != S_RESP) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == {CA{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						item_q       <= q_item;
						srch_idx_q   <= '0;
						cmp_v_q      <= 1'b0;
						res_doc_q[0] <= '0;
						res_doc_q[1] <= '0;
						res_doc_q[2] <= '0;
						case (q_item.act)
							ACT_LONG: begin
								res_status_q <= ST_LONG;
								state_q      <= S_RESP;
							end
							ACT_SHORT: begin
								res_status_q <= ST_SHORT;
								state_q      <= S_RESP;
							end
							default: begin
								state_q <= S_SRCH;
							end
						endcase
					end
				end
				S_SRCH: begin
					if (match) begin
						place_q  <= cmp_idx_q;
						cmp_v_q  <= 1'b0;
						rank_d_q <= '0;
						rank_v_q <= 1'b0;
						fill_q   <= 2'd0;
						state_q  <= (item_q.act == ACT_INDEX) ? S_INC_RD : S_RANK;
					end else if (srch_idx_q < total_q) begin
						cmp_v_q    <= 1'b1;
						cmp_idx_q  <= srch_idx_q[WIW-1:0];
						srch_idx_q <= srch_idx_q + 1'b1;
					end else if (cmp_v_q) begin
						cmp_v_q <= 1'b0;
					end else if (item_q.act != ACT_INDEX) begin
						res_status_q <= ST_NOT_FOUND;
						state_q      <= S_RESP;
					end else if (int'(total_q) >= MAX_WORDS) begin
						res_status_q <= ST_FULL;
						state_q      <= S_RESP;
					end else begin
						place_q <= total_q[WIW-1:0];
						total_q <= total_q + 1'b1;
						state_q <= S_INC_RD;
					end
				end
				S_INC_RD: begin
					state_q <= S_INC_WR;
				end
				S_INC_WR: begin
					res_status_q <= ST_COUNTED;
					state_q      <= S_RESP;
				end
				S_RANK: begin
					if (int'(rank_d_q) < MAX_DOCS) begin
						rank_v_q   <= 1'b1;
						rank_tag_q <= rank_d_q[DW-1:0];
						rank_d_q   <= rank_d_q + 1'b1;
					end else begin
						rank_v_q <= 1'b0;
					end
					if (rank_v_q) begin
						for (int j = 0; j < 3; j++) begin
							best_doc_q[j] <= nb_doc[j];
							best_cnt_q[j] <= nb_cnt[j];
						end
						if (fill_q != 2'd3) begin
							fill_q <= fill_q + 2'd1;
						end
					end else if (int'(rank_d_q) >= MAX_DOCS) begin
						res_status_q <= ST_FOUND;
						for (int j = 0; j < 3; j++) begin
							res_doc_q[j] <= 6'(best_doc_q[j]);
						end
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid  <= 1'b1;
						status     <= res_status_q;
						doc_first  <= res_doc_q[0];
						doc_second <= res_doc_q[1];
						doc_third  <= res_doc_q[2];
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/term_frequency_index_top3_core.sv @@
// Channel  Handshake            Beat contents
// in       in_valid/in_stall    kind, word_head, word_middle, word_tail, word_length, doc_index
// out      out_valid/out_stall  status, doc_first, doc_second, doc_third
// config   min_word_length_we   min_word_length
//
// A token or query first walks the vocabulary, since the vocabulary memory is read one entry
// a cycle; an indexed token then updates its count, and a found query ranks the count memory
// row over every document.
// After reset the count memory is cleared one entry a cycle, MAX_WORDS rounded up to a
// power of two times MAX_DOCS rounded up (65536 entries by default); beats queue meanwhile.
// A two-beat queue lets input beats wait while the back end works or out_stall holds it.
module term_frequency_index_top3_core #(
	parameter int MAX_WORDS    = 1024,
	parameter int MAX_DOCS     = 64,
	parameter int MAX_WORD_LEN = 20,
	parameter int COUNT_WIDTH  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        min_word_length_we,
	input  logic [4:0]  min_word_length,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [63:0] word_head,
	input  logic [63:0] word_middle,
	input  logic [31:0] word_tail,
	input  logic [5:0]  word_length,
	input  logic [5:0]  doc_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [5:0]  doc_first,
	output logic [5:0]  doc_second,
	output logic [5:0]  doc_third
);
	import tfi_pkg::*;

	logic  q_valid;
	logic  q_pop;
	item_t q_item;
	logic [1:0] q_level;

	tfi_front #(.MAX_DOCS(MAX_DOCS), .MAX_WORD_LEN(MAX_WORD_LEN)) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.min_word_length_we (min_word_length_we),
		.min_word_length    (min_word_length),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.kind               (kind),
		.word_head          (word_head),
		.word_middle        (word_middle),
		.word_tail          (word_tail),
		.word_length        (word_length),
		.doc_index          (doc_index),
		.q_valid            (q_valid),
		.q_pop              (q_pop),
		.q_item             (q_item),
		.q_level            (q_level)
	);

	tfi_back #(.MAX_WORDS(MAX_WORDS), .MAX_DOCS(MAX_DOCS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_item     (q_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.doc_first  (doc_first),
		.doc_second (doc_second),
		.doc_third  (doc_third)
	);

`include "term_frequency_index_top3_core_assert.svh"

	`TFI_ASSERT_NOW(a_docs_zero, out_valid && status != ST_FOUND, (doc_first | doc_second | doc_third) == 6'd0, "document fields set without a found query")
	`TFI_ASSERT_NOW(a_pop_valid, q_pop, q_valid && q_level != 2'd0, "queue popped while empty")
	`TFI_ASSERT_NOW(a_stall_full, in_stall, q_level == 2'd2, "input stalled while queue has room")

endmodule
